/* hw/rtl/trpm_pkg.sv */
// shared widths, constants and types of the throughput rate peak monitor
package trpm_pkg;

  localparam int TIME_W   = 32;
  localparam int CNT_W    = 48;
  localparam int SPAN_W   = 11;
  localparam int PIX_W    = 16;
  localparam int REM_W    = 10;
  localparam int DIVD_W   = 58;
  localparam int DIVS_W   = 32;
  localparam int MS_PER_S = 1000;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 11'd256;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [DIVS_W-1:0] rem;
  } div_res_t;

endpackage

/* hw/rtl/trpm_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module trpm_div
  import trpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output div_res_t          res
);

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quot_r, quot_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [DIVS_W:0]   trial;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quot_r[DIVD_W-1]};
    if (step_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIVS_W'(trial - {1'b0, dvs_r});
        quot_nxt = {quot_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        quot_nxt = {quot_r[DIVD_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      done_nxt = (step_r == STEP_W'(1));
    end else if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(DIVD_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule

/* hw/rtl/throughput_rate_peak_monitor_top.sv */
// top level of the throughput rate peak monitor: sequencer, window and history memories
//
// One item is one timer tick carrying a millisecond time and the cumulative down
// and up byte counters. A tick with zero elapsed time, or one that advances no
// whole scroll pixel, gives no result and changes nothing. Otherwise the block
// computes both directions' rates in bytes per second, averages each over the
// newest AVG_DEPTH rates, pushes the larger of the two averages into a history
// ring of at most cfg_wr_data (history_span) entries, a zero span read as one and
// a span above HIST_DEPTH as HIST_DEPTH, and walks that ring to find the peak,
// which replaces the held peak when it is higher or below three quarters of it.
// One item is worked on at a time; in_stall is high from acceptance until the
// result is loaded into the output register. The scroll pixels come from a
// reciprocal multiply by 1/1000. The shared bit-serial divider then works out
// the two rates and the two averages in turn, and the history walk reads one
// entry per cycle, newest first, over the kept entries, the earlier entries
// still in the ring (at most history_span - 1). A tick with zero elapsed time
// is dropped in the check step and one with no whole pixel in the pixel step,
// both with no result.
module throughput_rate_peak_monitor_top
  import trpm_pkg::*;
#(
  parameter int AVG_DEPTH         = 8,
  parameter int HIST_DEPTH        = 1024,
  parameter int PIXELS_PER_SECOND = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic [CNT_W-1:0]  in_down_total,
  input  logic [CNT_W-1:0]  in_up_total,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_scroll_pixels,
  output logic [CNT_W-1:0]  out_down_avg_rate,
  output logic [CNT_W-1:0]  out_up_avg_rate,
  output logic [CNT_W-1:0]  out_peak_rate,
  output logic              out_rescaled,
  input  logic              cfg_wr_en,
  input  logic [SPAN_W-1:0] cfg_wr_data
);

  // window ring and fill widths
  localparam int AW    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CW    = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W = CNT_W + CW;
  // history ring and fill widths
  localparam int HW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FW    = $clog2(HIST_DEPTH + 1);
  localparam int SP_W  = (FW > SPAN_W) ? FW : SPAN_W;
  // scroll arithmetic
  localparam int PPS_W = $clog2(PIXELS_PER_SECOND + 1);
  localparam int SC_W  = TIME_W + 1 + PPS_W;
  // scaled / 1000 as (scaled / 8) / 125 by reciprocal multiply
  localparam int SD_W  = SC_W - 3;
  localparam int RS    = SD_W + 7;
  localparam int PR_W  = 2 * SD_W + 1;
  localparam int QW    = PR_W - RS;

  localparam logic [CW-1:0]   AVG_FULL  = CW'(AVG_DEPTH);
  localparam logic [AW-1:0]   AVG_LAST  = AW'(AVG_DEPTH - 1);
  localparam logic [HW-1:0]   HIST_LAST = HW'(HIST_DEPTH - 1);
  localparam logic [SP_W-1:0] HIST_MAX  = SP_W'(HIST_DEPTH);
  localparam logic [SC_W-1:0] PPS_L     = SC_W'(PIXELS_PER_SECOND);
  localparam logic [SC_W-1:0] MS_L      = SC_W'(MS_PER_S);
  localparam logic [63:0]     RECIP_FULL = ((64'd1 << RS) + 64'd124) / 64'd125;
  localparam logic [SD_W:0]   RECIP_125  = RECIP_FULL[SD_W:0];

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CHK  = 9'b000000010,
    ST_PIX  = 9'b000000100,
    ST_DR   = 9'b000001000,
    ST_UR   = 9'b000010000,
    ST_DA   = 9'b000100000,
    ST_UA   = 9'b001000000,
    ST_WALK = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration and committed scalar state
  logic [SPAN_W-1:0] span_r;
  logic [TIME_W-1:0] prev_time_r, prev_time_nxt;
  logic [CNT_W-1:0]  prev_down_r, prev_down_nxt;
  logic [CNT_W-1:0]  prev_up_r, prev_up_nxt;
  logic [REM_W-1:0]  scroll_rem_r, scroll_rem_nxt;
  logic [CW-1:0]     win_fill_r, win_fill_nxt;
  logic [AW-1:0]     win_pos_r, win_pos_nxt;
  logic [SUM_W-1:0]  down_sum_r, down_sum_nxt;
  logic [SUM_W-1:0]  up_sum_r, up_sum_nxt;
  logic [FW-1:0]     hist_fill_r, hist_fill_nxt;
  logic [HW-1:0]     hist_pos_r, hist_pos_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;

  // per-item working registers
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  dtot_r, dtot_nxt;
  logic [CNT_W-1:0]  utot_r, utot_nxt;
  logic [SC_W-1:0]   scaled_r, scaled_nxt;
  logic [QW-1:0]     pix_q_r, pix_q_nxt;
  logic [REM_W-1:0]  rem_tmp_r, rem_tmp_nxt;
  logic [PIX_W-1:0]  pix_r, pix_nxt;
  logic [CNT_W-1:0]  drate_r, drate_nxt;
  logic [CNT_W-1:0]  davg_r, davg_nxt;
  logic [CNT_W-1:0]  uavg_r, uavg_nxt;
  logic [CNT_W-1:0]  peak_r, peak_nxt;
  logic [HW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]     walk_cnt_r, walk_cnt_nxt;
  logic              rd_vld_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  o_pix_r;
  logic [CNT_W-1:0]  o_davg_r, o_uavg_r, o_peak_r;
  logic              o_resc_r;
  logic              out_load;

  // memories
  logic [2*CNT_W-1:0] win_mem [AVG_DEPTH];
  logic [2*CNT_W-1:0] win_rd_r;
  logic [CNT_W-1:0]   hist_mem [HIST_DEPTH];
  logic [CNT_W-1:0]   hist_rd_r;
  logic               win_we, hist_we, hist_re;
  logic [CNT_W-1:0]   hist_wdata;

  // divider
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  div_res_t          div_res;

  // datapath helpers
  logic              in_accept;
  logic [TIME_W-1:0] tdiff;
  logic [SC_W-1:0]   scaled;
  logic [PR_W-1:0]   pix_prod;
  logic [QW+9:0]     pix_k;
  logic [SC_W-1:0]   rem_calc;
  logic [CNT_W-1:0]  dbytes, ubytes;
  logic [DIVD_W-1:0] dbytes_k, ubytes_k;
  logic [CNT_W-1:0]  rate_sat;
  logic [CNT_W-1:0]  old_down, old_up;
  logic              win_full;
  logic [CNT_W-1:0]  new_max;
  logic [SP_W-1:0]   span_c, span_e, fill_x, kept_x;
  logic [CNT_W+1:0]  held_x3;
  logic [CNT_W-1:0]  held_34;
  logic              rescale;

  trpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);

  // elapsed time and scroll scaling, all modulo their field widths
  assign tdiff  = now_r - prev_time_r;
  assign scaled = (SC_W'(tdiff) + SC_W'(scroll_rem_r)) * PPS_L;
  // whole pixels by reciprocal of 125 on scaled / 8, exact over the full range
  assign pix_prod = PR_W'(scaled_r[SC_W-1:3]) * PR_W'(RECIP_125);
  // remainder as scaled - pixels * 1000, with 1000 as 1024 - 16 - 8
  assign pix_k    = {pix_q_r, 10'd0} - {6'd0, pix_q_r, 4'd0} - {7'd0, pix_q_r, 3'd0};
  assign rem_calc = scaled_r - pix_k[SC_W-1:0];
  assign dbytes = dtot_r - prev_down_r;
  assign ubytes = utot_r - prev_up_r;
  // bytes * 1000 as 1024 - 16 - 8
  assign dbytes_k = {dbytes, 10'd0} - {6'd0, dbytes, 4'd0} - {7'd0, dbytes, 3'd0};
  assign ubytes_k = {ubytes, 10'd0} - {6'd0, ubytes, 4'd0} - {7'd0, ubytes, 3'd0};
  assign rate_sat = (|div_res.quot[DIVD_W-1:CNT_W]) ? {CNT_W{1'b1}}
                                                     : div_res.quot[CNT_W-1:0];

  assign old_down = win_rd_r[2*CNT_W-1:CNT_W];
  assign old_up   = win_rd_r[CNT_W-1:0];
  assign win_full = (win_fill_r == AVG_FULL);

  assign new_max = (davg_r > div_res.quot[CNT_W-1:0]) ? davg_r : div_res.quot[CNT_W-1:0];

  // effective span clamped to 1..HIST_DEPTH, newest entries kept on shrink
  assign span_c = (span_r == '0) ? SP_W'(1) : SP_W'(span_r);
  assign span_e = (span_c > HIST_MAX) ? HIST_MAX : span_c;
  assign fill_x = SP_W'(hist_fill_r);
  assign kept_x = (fill_x < span_e - 1'b1) ? fill_x : span_e - 1'b1;

  assign held_x3 = {2'd0, held_r} + {1'b0, held_r, 1'b0};
  assign held_34 = held_x3[CNT_W+1:2];
  assign rescale = (peak_r > held_r) || (held_34 > peak_r);

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    prev_time_nxt  = prev_time_r;
    prev_down_nxt  = prev_down_r;
    prev_up_nxt    = prev_up_r;
    scroll_rem_nxt = scroll_rem_r;
    win_fill_nxt   = win_fill_r;
    win_pos_nxt    = win_pos_r;
    down_sum_nxt   = down_sum_r;
    up_sum_nxt     = up_sum_r;
    hist_fill_nxt  = hist_fill_r;
    hist_pos_nxt   = hist_pos_r;
    held_nxt       = held_r;
    now_nxt        = now_r;
    dtot_nxt       = dtot_r;
    utot_nxt       = utot_r;
    scaled_nxt     = scaled_r;
    pix_q_nxt      = pix_q_r;
    rem_tmp_nxt    = rem_tmp_r;
    pix_nxt        = pix_r;
    drate_nxt      = drate_r;
    davg_nxt       = davg_r;
    uavg_nxt       = uavg_r;
    peak_nxt       = peak_r;
    rd_ptr_nxt     = rd_ptr_r;
    walk_cnt_nxt   = walk_cnt_r;
    div_start      = 1'b0;
    div_dividend   = dbytes_k;
    div_divisor    = tdiff;
    win_we         = 1'b0;
    hist_we        = 1'b0;
    hist_re        = 1'b0;
    hist_wdata     = new_max;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          now_nxt   = in_now_ms;
          dtot_nxt  = in_down_total;
          utot_nxt  = in_up_total;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        // zero elapsed time drops the tick
        if (tdiff == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          scaled_nxt = scaled;
          state_nxt  = ST_PIX;
        end
      end
      ST_PIX: begin
        // less than one whole pixel drops the tick
        if (scaled_r < MS_L) begin
          state_nxt = ST_IDLE;
        end else begin
          pix_q_nxt    = pix_prod[PR_W-1:RS];
          div_start    = 1'b1;
          div_dividend = dbytes_k;
          div_divisor  = tdiff;
          state_nxt    = ST_DR;
        end
      end
      ST_DR: begin
        if (div_res.done) begin
          drate_nxt    = rate_sat;
          pix_nxt      = (|pix_q_r[QW-1:PIX_W]) ? {PIX_W{1'b1}} : pix_q_r[PIX_W-1:0];
          rem_tmp_nxt  = rem_calc[REM_W-1:0];
          div_start    = 1'b1;
          div_dividend = ubytes_k;
          div_divisor  = tdiff;
          state_nxt    = ST_UR;
        end
      end
      ST_UR: begin
        if (div_res.done) begin
          // window read-modify-write: running sums drop the overwritten entry
          win_we       = 1'b1;
          down_sum_nxt = down_sum_r - (win_full ? SUM_W'(old_down) : '0) + SUM_W'(drate_r);
          up_sum_nxt   = up_sum_r - (win_full ? SUM_W'(old_up) : '0) + SUM_W'(rate_sat);
          win_fill_nxt = win_full ? win_fill_r : win_fill_r + 1'b1;
          win_pos_nxt  = (win_pos_r == AVG_LAST) ? '0 : win_pos_r + 1'b1;
          // tick is committed from here on
          prev_time_nxt  = now_r;
          prev_down_nxt  = dtot_r;
          prev_up_nxt    = utot_r;
          scroll_rem_nxt = rem_tmp_r;
          div_start      = 1'b1;
          div_dividend   = DIVD_W'(down_sum_nxt);
          div_divisor    = DIVS_W'(win_fill_nxt);
          state_nxt      = ST_DA;
        end
      end
      ST_DA: begin
        if (div_res.done) begin
          davg_nxt     = div_res.quot[CNT_W-1:0];
          div_start    = 1'b1;
          div_dividend = DIVD_W'(up_sum_r);
          div_divisor  = DIVS_W'(win_fill_r);
          state_nxt    = ST_UA;
        end
      end
      ST_UA: begin
        if (div_res.done) begin
          uavg_nxt      = div_res.quot[CNT_W-1:0];
          hist_we       = 1'b1;
          peak_nxt      = new_max;
          hist_fill_nxt = FW'(kept_x + 1'b1);
          walk_cnt_nxt  = FW'(kept_x);
          rd_ptr_nxt    = (hist_pos_r == '0) ? HIST_LAST : hist_pos_r - 1'b1;
          hist_pos_nxt  = (hist_pos_r == HIST_LAST) ? '0 : hist_pos_r + 1'b1;
          state_nxt     = ST_WALK;
        end
      end
      ST_WALK: begin
        // one read issued per cycle, newest kept entry first
        if (walk_cnt_r != '0) begin
          hist_re      = 1'b1;
          walk_cnt_nxt = walk_cnt_r - 1'b1;
          rd_ptr_nxt   = (rd_ptr_r == '0) ? HIST_LAST : rd_ptr_r - 1'b1;
        end
        if (rd_vld_r && (hist_rd_r > peak_r)) begin
          peak_nxt = hist_rd_r;
        end
        if ((walk_cnt_r == '0) && !rd_vld_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          if (rescale) begin
            held_nxt = peak_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      span_r       <= SPAN_RESET;
      prev_time_r  <= '0;
      prev_down_r  <= '0;
      prev_up_r    <= '0;
      scroll_rem_r <= '0;
      win_fill_r   <= '0;
      win_pos_r    <= '0;
      down_sum_r   <= '0;
      up_sum_r     <= '0;
      hist_fill_r  <= '0;
      hist_pos_r   <= '0;
      held_r       <= '0;
      walk_cnt_r   <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        span_r <= cfg_wr_data;
      end
      prev_time_r  <= prev_time_nxt;
      prev_down_r  <= prev_down_nxt;
      prev_up_r    <= prev_up_nxt;
      scroll_rem_r <= scroll_rem_nxt;
      win_fill_r   <= win_fill_nxt;
      win_pos_r    <= win_pos_nxt;
      down_sum_r   <= down_sum_nxt;
      up_sum_r     <= up_sum_nxt;
      hist_fill_r  <= hist_fill_nxt;
      hist_pos_r   <= hist_pos_nxt;
      held_r       <= held_nxt;
      walk_cnt_r   <= walk_cnt_nxt;
      rd_vld_r     <= hist_re;
      out_valid_r  <= out_valid_nxt;
    end
    now_r     <= now_nxt;
    dtot_r    <= dtot_nxt;
    utot_r    <= utot_nxt;
    scaled_r  <= scaled_nxt;
    pix_q_r   <= pix_q_nxt;
    rem_tmp_r <= rem_tmp_nxt;
    pix_r     <= pix_nxt;
    drate_r   <= drate_nxt;
    davg_r    <= davg_nxt;
    uavg_r    <= uavg_nxt;
    peak_r    <= peak_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    if (out_load) begin
      o_pix_r  <= pix_r;
      o_davg_r <= davg_r;
      o_uavg_r <= uavg_r;
      o_peak_r <= rescale ? peak_r : held_r;
      o_resc_r <= rescale;
    end
  end

  // rate window: one entry read at the ring position every cycle
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_pos_r] <= {drate_r, rate_sat};
    end
    win_rd_r <= win_mem[win_pos_r];
  end

  // history ring of the larger average per tick
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_pos_r] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[rd_ptr_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scroll_pixels = o_pix_r;
  assign out_down_avg_rate = o_davg_r;
  assign out_up_avg_rate   = o_uavg_r;
  assign out_peak_rate     = o_peak_r;
  assign out_rescaled      = o_resc_r;

  // a new result only comes out of the final step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside final step");

  // window and history fills stay within their stores
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (win_fill_r <= AVG_FULL) && (hist_fill_r <= FW'(HIST_DEPTH)))
    else $error("fill count beyond store depth");

  // the walk never reads more entries than kept
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (walk_cnt_r < hist_fill_r))
    else $error("history walk beyond kept entries");

  // divider results only arrive while waiting on one
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DR || state_r == ST_UR ||
                      state_r == ST_DA || state_r == ST_UA))
    else $error("divider done outside a divide step");

endmodule

/* test/throughput_rate_peak_monitor_top_tb.sv */
// testbench of the throughput rate peak monitor: directed table, random ticks, predictor check
module throughput_rate_peak_monitor_top_tb;
  import trpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AVG_N      = 8;
  localparam int HIST_N     = 1024;
  localparam int PIX_PER_S  = 2;
  localparam int WATCHDOG   = 50000;
  localparam int DRAIN_WAIT = 100;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [CNT_W-1:0]  down;
    logic [CNT_W-1:0]  up;
  } tick_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [CNT_W-1:0] down_avg;
    logic [CNT_W-1:0] up_avg;
    logic [CNT_W-1:0] peak;
    logic             rescaled;
  } rate_res_t;

  typedef struct packed {
    tick_t     tick;
    logic      typed;
    rate_res_t res;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic [CNT_W-1:0]  in_down_total = '0;
  logic [CNT_W-1:0]  in_up_total = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PIX_W-1:0]  out_scroll_pixels;
  logic [CNT_W-1:0]  out_down_avg_rate;
  logic [CNT_W-1:0]  out_up_avg_rate;
  logic [CNT_W-1:0]  out_peak_rate;
  logic              out_rescaled;
  logic              cfg_wr_en = 1'b0;
  logic [SPAN_W-1:0] cfg_wr_data = '0;

  always #5 clk = ~clk;

  throughput_rate_peak_monitor_top DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_now_ms, .in_down_total, .in_up_total,
    .out_valid, .out_stall, .out_scroll_pixels, .out_down_avg_rate,
    .out_up_avg_rate, .out_peak_rate, .out_rescaled,
    .cfg_wr_en, .cfg_wr_data
  );

  // predictor state, mirrors the block after reset
  logic [SPAN_W-1:0] span_reg = SPAN_RESET;
  logic [TIME_W-1:0] last_time = '0;
  logic [CNT_W-1:0]  last_down = '0;
  logic [CNT_W-1:0]  last_up = '0;
  int unsigned       pix_rem = 0;
  logic [CNT_W-1:0]  win_down [AVG_N];
  logic [CNT_W-1:0]  win_up [AVG_N];
  int unsigned       win_fill = 0;
  int unsigned       win_pos = 0;
  logic [CNT_W-1:0]  hist_down [HIST_N];
  logic [CNT_W-1:0]  hist_up [HIST_N];
  int unsigned       hist_fill = 0;
  int unsigned       hist_pos = 0;
  logic [CNT_W-1:0]  held_max = '0;

  rate_res_t expected_rates [$];
  int errors = 0;
  int ticks_sent = 0;
  int ticks_dropped = 0;
  int results_seen = 0;
  int rescales_seen = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic [CNT_W-1:0] bytes_per_sec(logic [CNT_W-1:0] bytes,
                                                   logic [TIME_W-1:0] ms);
    logic [63:0] r;
    r = 64'(bytes) * 64'd1000 / 64'(ms);
    return (r > 64'(CNT_MAX)) ? CNT_MAX : r[CNT_W-1:0];
  endfunction

  // returns 1 when the tick gives a result, updating the predictor state
  function automatic bit predict_rates(input tick_t t, output rate_res_t r);
    logic [TIME_W-1:0] dt;
    logic [63:0]       scaled, pixels, sum_d, sum_u;
    logic [CNT_W-1:0]  rd, ru, ad, au, pk;
    int unsigned       span, kept, idx;
    bit                resc;
    r = '0;
    dt = t.now - last_time;
    if (dt == 0) return 0;
    scaled = (64'(dt) + 64'(pix_rem)) * 64'(PIX_PER_S);
    pixels = scaled / 64'd1000;
    if (pixels == 0) return 0;
    pix_rem = int'(scaled - pixels * 64'd1000);
    rd = bytes_per_sec(t.down - last_down, dt);
    ru = bytes_per_sec(t.up - last_up, dt);
    // moving average over the newest rates
    win_down[win_pos] = rd;
    win_up[win_pos] = ru;
    win_pos = (win_pos + 1) % AVG_N;
    if (win_fill < AVG_N) win_fill++;
    sum_d = 0;
    sum_u = 0;
    for (int k = 0; k < win_fill; k++) begin
      sum_d += 64'(win_down[k]);
      sum_u += 64'(win_up[k]);
    end
    ad = CNT_W'(sum_d / 64'(win_fill));
    au = CNT_W'(sum_u / 64'(win_fill));
    // bounded history, zero span acts as one
    span = (span_reg == 0) ? 1 : int'(span_reg);
    if (span > HIST_N) span = HIST_N;
    kept = (hist_fill < span - 1) ? hist_fill : span - 1;
    hist_down[hist_pos] = ad;
    hist_up[hist_pos] = au;
    hist_pos = (hist_pos + 1) % HIST_N;
    hist_fill = kept + 1;
    pk = '0;
    for (int k = 0; k < hist_fill; k++) begin
      idx = (hist_pos + HIST_N - 1 - k) % HIST_N;
      if (hist_down[idx] > pk) pk = hist_down[idx];
      if (hist_up[idx] > pk) pk = hist_up[idx];
    end
    resc = (pk > held_max) || ((64'(held_max) * 3 / 4) > 64'(pk));
    if (resc) held_max = pk;
    last_time = t.now;
    last_down = t.down;
    last_up = t.up;
    r.pix = (pixels > 64'hFFFF) ? 16'hFFFF : pixels[PIX_W-1:0];
    r.down_avg = ad;
    r.up_avg = au;
    r.peak = held_max;
    r.rescaled = resc;
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side: random stall, compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    rate_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_rates.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_rates.pop_front();
        if (out_rescaled) rescales_seen++;
        if (out_scroll_pixels !== e.pix)
          report_mismatch("scroll_pixels", out_scroll_pixels, e.pix);
        if (out_down_avg_rate !== e.down_avg)
          report_mismatch("down_avg_rate", out_down_avg_rate, e.down_avg);
        if (out_up_avg_rate !== e.up_avg)
          report_mismatch("up_avg_rate", out_up_avg_rate, e.up_avg);
        if (out_peak_rate !== e.peak)
          report_mismatch("peak_rate", out_peak_rate, e.peak);
        if (out_rescaled !== e.rescaled)
          report_mismatch("rescaled", out_rescaled, e.rescaled);
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("timeout after %0d quiet cycles", WATCHDOG);
        $display("status: fail");
        $finish;
      end
    end
  end

  // offer one tick, optionally after an idle gap, and predict on acceptance
  task automatic send_tick(input tick_t t, input bit typed, input rate_res_t typed_res);
    rate_res_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now_ms <= t.now;
    in_down_total <= t.down;
    in_up_total <= t.up;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
    if (predict_rates(t, r)) expected_rates.push_back(typed ? typed_res : r);
    else ticks_dropped++;
  endtask

  // wait for all results, then give a possible dropped tick time to finish
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_span(input logic [SPAN_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    span_reg = v;
  endtask

  // random tick that mostly advances time like a once-a-second timer
  function automatic tick_t next_tick(input tick_t p);
    tick_t t;
    int    kind;
    t = p;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      t.now = p.now + $urandom_range(500, 3000);
      t.down = p.down + (CNT_W'({$urandom, $urandom}) >> $urandom_range(0, 47));
      t.up = p.up + (CNT_W'({$urandom, $urandom}) >> $urandom_range(0, 47));
    end else if (kind < 85) begin
      t.now = p.now + $urandom_range(1, 499);
      t.down = p.down + $urandom_range(0, 100000);
    end else if (kind < 90) begin
      t.up = p.up + $urandom_range(0, 100000);
    end else if (kind < 95) begin
      t.now = $urandom;
      t.down = p.down + CNT_W'({$urandom, $urandom});
    end else begin
      t.now = $urandom;
      t.down = CNT_W'({$urandom, $urandom});
      t.up = CNT_W'({$urandom, $urandom});
    end
    return t;
  endfunction

  row_t        dir_rows [$];
  tick_t       cur;
  int          span_plan [] = '{3, 1, 1024, 0, 2047, 17, 256};
  logic [CNT_W-1:0] mix_a = 48'hAAAA_AAAA_AAAA;
  logic [CNT_W-1:0] mix_b = 48'h5555_5555_5555;

  initial begin
    // first tick after reset: 1000 ms and 1000 bytes down give 2 pixels and 1000 B/s
    dir_rows.push_back('{'{32'd1000, 48'd1000, 48'd0}, 1'b1,
                         '{16'd2, 48'd1000, 48'd0, 48'd1000, 1'b1}});
    // zero elapsed time, then too little time for a whole pixel
    dir_rows.push_back('{'{32'd1000, 48'd5000, 48'd7}, 1'b0, '0});
    dir_rows.push_back('{'{32'd1100, 48'd5000, 48'd7}, 1'b0, '0});
    dir_rows.push_back('{'{32'd1499, 48'd5000, 48'd7}, 1'b0, '0});
    // just one pixel; up counter jump saturates the rate
    dir_rows.push_back('{'{32'd1500, 48'h8000_0000_03E8, CNT_MAX}, 1'b0, '0});
    // huge elapsed time saturates the pixel count
    dir_rows.push_back('{'{32'hFFFF_FE00, CNT_MAX, 48'd0}, 1'b0, '0});
    // time and both counters wrap
    dir_rows.push_back('{'{32'h0000_0100, 48'd5, 48'd3}, 1'b0, '0});
    dir_rows.push_back('{'{32'hFFFF_FFFF, mix_a, mix_b}, 1'b0, '0});
    dir_rows.push_back('{'{32'h5555_5555, mix_b, mix_a}, 1'b0, '0});
    dir_rows.push_back('{'{32'hAAAA_AAAA, 48'd0, CNT_MAX}, 1'b0, '0});
    dir_rows.push_back('{'{32'hAAAA_B2AA, 48'd0, CNT_MAX}, 1'b0, '0});
    for (int k = 0; k < 8; k++)
      dir_rows.push_back('{'{32'hAAAA_B2AA + 32'(1000 * (k + 1)), 48'(k * 777),
                             CNT_MAX}, 1'b0, '0});
    dir_rows.push_back('{'{32'd0, 48'd0, 48'd0}, 1'b0, '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table with the block at its reset span
    send_idle_pct = 27;
    recv_stall_pct = 86;
    foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // random phases, each at its own span; idling swaps sides, then stops
    cur = '{32'd0, 48'd0, 48'd0};
    foreach (span_plan[p]) begin
      if (p == 2) begin
        send_idle_pct = 86;
        recv_stall_pct = 27;
      end else if (p == 5) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_span(SPAN_W'(span_plan[p]));
      for (int n = 0; n < 36; n++) begin
        cur = next_tick(cur);
        send_tick(cur, 1'b0, '0);
      end
      drain();
    end

    $display("covered %0d ticks (%0d dropped), %0d results checked, %0d peak rescales",
             ticks_sent, ticks_dropped, results_seen, rescales_seen);
    $display("history spans 256, 3, 1, 1024, 0, 2047, 17 under three idling patterns");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/trpm_pkg.sv
hw/rtl/trpm_div.sv
hw/rtl/throughput_rate_peak_monitor_top.sv
test/throughput_rate_peak_monitor_top_tb.sv
